@@ hdl/cst_pkg.sv @@
// cst_pkg: shared types and codes of the counting semaphore table unit
// operation codes, status codes and the command word passed front to back
// no dependencies
package cst_pkg;

	localparam logic [1:0] OP_CREATE  = 2'd0;
	localparam logic [1:0] OP_DESTROY = 2'd1;
	localparam logic [1:0] OP_DOWN    = 2'd2;
	localparam logic [1:0] OP_UP      = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_QUEUED     = 3'd1;
	localparam logic [2:0] ST_NOT_IN_USE = 3'd2;
	localparam logic [2:0] ST_QUEUE_FULL = 3'd3;
	localparam logic [2:0] ST_DENIED     = 3'd4;

	localparam int SCAN_W = 16;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] key;
		logic [7:0] pid;
		logic [7:0] start_count;
		logic       key_ok;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_head_t;

endpackage

@@ hdl/cst_if.sv @@
// cst_req_if, cst_rsp_if: valid/ready channels for requests and results
// no dependencies
interface cst_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] key;
	logic [7:0] pid;
	logic [7:0] start_count;
	modport source (output valid, op, key, pid, start_count, input ready);
	modport sink (input valid, op, key, pid, start_count, output ready);
endinterface

interface cst_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] new_key;
	logic       woken_valid;
	logic [7:0] woken_pid;
	modport source (output valid, status, new_key, woken_valid, woken_pid, input ready);
	modport sink (input valid, status, new_key, woken_valid, woken_pid, output ready);
endinterface

@@ hdl/counting_semaphore_table_unit.sv @@
// counting_semaphore_table_unit: top level of the counting semaphore table
// depends on cst_pkg, cst_req_if, cst_rsp_if, cst_front and cst_back
// A request is taken into a two-entry queue and gives exactly one result. Once a command
// reaches the back end, destroy, down and up without a waiter are done in the execute
// state, up with a waiter goes on from there to the wake state, and create is done in the
// scan state, where the free-entry scan checks the in-use flags 16 entries a cycle. The next
// command starts in the cycle after the result transfer. Key 0 is reserved; create returns
// key 0 when the table is full. Up saturates the count at 255.
module counting_semaphore_table_unit #(
	parameter int NUM_SEMAPHORES = 256,
	parameter int QUEUE_DEPTH    = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	cst_req_if.sink   req,
	cst_rsp_if.source rsp
);

	cst_pkg::cmd_head_t head;
	logic               pop;

	cst_front #(
		.NUM_SEMAPHORES(NUM_SEMAPHORES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.head   (head),
		.pop    (pop)
	);

	cst_back #(
		.NUM_SEMAPHORES(NUM_SEMAPHORES),
		.QUEUE_DEPTH   (QUEUE_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

@@ hdl/cst_front.sv @@
// cst_front: accepts requests, checks the key range, holds a two-entry queue
// depends on cst_pkg and cst_req_if
module cst_front #(
	parameter int NUM_SEMAPHORES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	cst_req_if.sink           req,
	output cst_pkg::cmd_head_t head,
	input  logic              pop
);

	cst_pkg::cmd_t ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	cst_pkg::cmd_t in_cmd;

	assign req.ready = (cnt_q != 2'd2);
	assign push = req.valid && req.ready;

	always_comb begin
		in_cmd.op = req.op;
		in_cmd.key = req.key;
		in_cmd.pid = req.pid;
		in_cmd.start_count = req.start_count;
		in_cmd.key_ok = (req.key != 8'd0) && ({1'b0, req.key} < 9'(NUM_SEMAPHORES));
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ hdl/cst_back.sv @@
// cst_back: sequencer that carries out one command against the semaphore table
// holds the in-use flags, the entry memories, the wait-slot memory and the result register
// depends on cst_pkg and cst_rsp_if
module cst_back #(
	parameter int NUM_SEMAPHORES = 256,
	parameter int QUEUE_DEPTH    = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cst_pkg::cmd_head_t head,
	output logic               pop,
	cst_rsp_if.source          rsp
);

	localparam int KW   = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
	localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW   = $clog2(QUEUE_DEPTH + 1);
	localparam int WD   = NUM_SEMAPHORES * QUEUE_DEPTH;
	localparam int WAW  = (WD > 1) ? $clog2(WD) : 1;
	localparam int CW   = cst_pkg::SCAN_W;
	localparam int NCH  = (NUM_SEMAPHORES + CW - 1) / CW;
	localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PADW = NCH * CW;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;
	localparam logic [1:0] S_WAKE = 2'd3;

	logic [1:0]    state_q;
	cst_pkg::cmd_t cmd_q;
	logic [CHW-1:0] chunk_q;
	logic [NUM_SEMAPHORES-1:0] in_use_q;

	logic [7:0]    cre_mem  [NUM_SEMAPHORES];
	logic [7:0]    cnt_mem  [NUM_SEMAPHORES];
	logic [PW-1:0] head_mem [NUM_SEMAPHORES];
	logic [FW-1:0] fill_mem [NUM_SEMAPHORES];
	logic [7:0]    wait_mem [WD];

	logic [7:0]    cre_q;
	logic [7:0]    cnt_q;
	logic [PW-1:0] hd_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    wpid_q;

	logic          out_vld_q;
	logic [2:0]    status_q;
	logic [7:0]    new_key_q;
	logic          woken_valid_q;
	logic [7:0]    woken_pid_q;

	logic [KW-1:0] rd_idx;
	logic [KW-1:0] idx;
	logic          e_we;
	logic [KW-1:0] e_addr;
	logic [7:0]    e_cre;
	logic [7:0]    e_cnt;
	logic [PW-1:0] e_head;
	logic [FW-1:0] e_fill;
	logic          w_we;
	logic          w_re;
	logic [WAW-1:0] w_addr;
	logic [PW-1:0] tail_pos;
	logic [PW-1:0] next_head;
	logic [PADW-1:0] used_pad;
	logic [CW-1:0] chunk_used;
	logic          found;
	logic [$clog2(CW)-1:0] found_j;
	logic [KW-1:0] found_idx;
	logic          live;

	assign rsp.valid = out_vld_q;
	assign rsp.status = status_q;
	assign rsp.new_key = new_key_q;
	assign rsp.woken_valid = woken_valid_q;
	assign rsp.woken_pid = woken_pid_q;

	assign pop = (state_q == S_IDLE) && head.valid && !out_vld_q;
	assign rd_idx = head.cmd.key[KW-1:0];
	assign idx = cmd_q.key[KW-1:0];
	assign live = cmd_q.key_ok && in_use_q[idx];

	always_comb begin
		logic [PW:0] sum;
		sum = {1'b0, hd_q} + (PW + 1)'(fill_q);
		if (sum >= (PW + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (PW + 1)'(QUEUE_DEPTH);
		end
		tail_pos = sum[PW-1:0];
		next_head = ({1'b0, hd_q} == (PW + 1)'(QUEUE_DEPTH - 1)) ? '0 : hd_q + PW'(1);
	end

	always_comb begin
		used_pad = '1;
		for (int i = 1; i < NUM_SEMAPHORES; i++) begin
			used_pad[i] = in_use_q[i];
		end
		chunk_used = used_pad[chunk_q * CW +: CW];
		found = 1'b0;
		found_j = '0;
		for (int j = CW - 1; j >= 0; j--) begin
			if (!chunk_used[j]) begin
				found = 1'b1;
				found_j = ($clog2(CW))'(j);
			end
		end
		found_idx = KW'(int'(chunk_q) * CW + int'(found_j));
	end

	always_comb begin
		e_we = 1'b0;
		e_addr = idx;
		e_cre = cre_q;
		e_cnt = cnt_q;
		e_head = hd_q;
		e_fill = fill_q;
		w_we = 1'b0;
		w_re = 1'b0;
		w_addr = WAW'(int'(idx) * QUEUE_DEPTH + int'(hd_q));
		case (state_q)
			S_SCAN: begin
				if (found && !out_vld_q) begin
					e_we = 1'b1;
					e_addr = found_idx;
					e_cre = cmd_q.pid;
					e_cnt = cmd_q.start_count;
					e_head = '0;
					e_fill = '0;
				end
			end
			S_EXEC: begin
				if (live && cmd_q.op == cst_pkg::OP_DOWN) begin
					if (cnt_q != 8'd0) begin
						e_we = 1'b1;
						e_cnt = cnt_q - 8'd1;
					end else if (fill_q < FW'(QUEUE_DEPTH)) begin
						e_we = 1'b1;
						e_fill = fill_q + FW'(1);
						w_we = 1'b1;
						w_addr = WAW'(int'(idx) * QUEUE_DEPTH + int'(tail_pos));
					end
				end else if (live && cmd_q.op == cst_pkg::OP_UP) begin
					e_we = 1'b1;
					if (fill_q != '0) begin
						e_head = next_head;
						e_fill = fill_q - FW'(1);
						w_re = 1'b1;
					end else if (cnt_q != 8'hff) begin
						e_cnt = cnt_q + 8'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			cre_mem[e_addr] <= e_cre;
			cnt_mem[e_addr] <= e_cnt;
			head_mem[e_addr] <= e_head;
			fill_mem[e_addr] <= e_fill;
		end
		if (pop) begin
			cre_q <= cre_mem[rd_idx];
			cnt_q <= cnt_mem[rd_idx];
			hd_q <= head_mem[rd_idx];
			fill_q <= fill_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			wait_mem[w_addr] <= cmd_q.pid;
		end
		if (w_re) begin
			wpid_q <= wait_mem[w_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chunk_q <= '0;
			in_use_q <= '0;
			out_vld_q <= 1'b0;
			status_q <= cst_pkg::ST_OK;
			new_key_q <= 8'd0;
			woken_valid_q <= 1'b0;
			woken_pid_q <= 8'd0;
		end else begin
			if (out_vld_q && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						chunk_q <= '0;
						state_q <= (head.cmd.op == cst_pkg::OP_CREATE) ? S_SCAN : S_EXEC;
					end
				end
				S_SCAN: begin
					if (found) begin
						in_use_q[found_idx] <= 1'b1;
						out_vld_q <= 1'b1;
						status_q <= cst_pkg::ST_OK;
						new_key_q <= 8'(found_idx);
						woken_valid_q <= 1'b0;
						woken_pid_q <= 8'd0;
						state_q <= S_IDLE;
					end else if (int'(chunk_q) == NCH - 1) begin
						out_vld_q <= 1'b1;
						status_q <= cst_pkg::ST_OK;
						new_key_q <= 8'd0;
						woken_valid_q <= 1'b0;
						woken_pid_q <= 8'd0;
						state_q <= S_IDLE;
					end else begin
						chunk_q <= chunk_q + CHW'(1);
					end
				end
				S_EXEC: begin
					new_key_q <= 8'd0;
					woken_valid_q <= 1'b0;
					woken_pid_q <= 8'd0;
					state_q <= S_IDLE;
					out_vld_q <= 1'b1;
					if (!live) begin
						status_q <= cst_pkg::ST_NOT_IN_USE;
					end else begin
						case (cmd_q.op)
							cst_pkg::OP_DESTROY: begin
								if (cre_q == cmd_q.pid) begin
									in_use_q[idx] <= 1'b0;
									status_q <= cst_pkg::ST_OK;
								end else begin
									status_q <= cst_pkg::ST_DENIED;
								end
							end
							cst_pkg::OP_DOWN: begin
								if (cnt_q != 8'd0) begin
									status_q <= cst_pkg::ST_OK;
								end else if (fill_q < FW'(QUEUE_DEPTH)) begin
									status_q <= cst_pkg::ST_QUEUED;
								end else begin
									status_q <= cst_pkg::ST_QUEUE_FULL;
								end
							end
							default: begin
								status_q <= cst_pkg::ST_OK;
								if (fill_q != '0) begin
									out_vld_q <= 1'b0;
									state_q <= S_WAKE;
								end
							end
						endcase
					end
				end
				default: begin
					out_vld_q <= 1'b1;
					status_q <= cst_pkg::ST_OK;
					woken_valid_q <= 1'b1;
					woken_pid_q <= wpid_q;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
